// ----- rtl/spba_pkg.sv -----
// shared constants, codes and word types of the segment pool bump allocator
package spba_pkg;

    localparam int unsigned SEGMENT_BYTES_DEF = 8192;
    localparam int unsigned MAX_SEGMENTS_DEF  = 64;

    localparam int unsigned KIND_W   = 1;
    localparam int unsigned SIZE_W   = 14;
    localparam int unsigned ADDR_W   = 19;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CNT_W    = 10;
    // rounded size of a 14 bit request needs one more bit
    localparam int unsigned RND_W    = SIZE_W + 1;

    localparam int unsigned RESERVED_BYTES = 4;
    localparam int unsigned ROUND_ADD      = 15;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SIZE_W-1:0] alloc_size;
        logic [ADDR_W-1:0] free_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   granted_address;
        logic [STATUS_W-1:0] status;
    } rsp_t;

endpackage

// ----- rtl/spba_req_if.sv -----
// request channel of the allocator
interface spba_req_if;
    logic          valid;
    logic          ready;
    spba_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/spba_rsp_if.sv -----
// response channel of the allocator
interface spba_rsp_if;
    logic          valid;
    logic          ready;
    spba_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/spba_count_store.sv -----
// live count memory with per-segment zero flags and first-empty-segment search
module spba_count_store #(
    parameter int unsigned MAX_SEGMENTS = spba_pkg::MAX_SEGMENTS_DEF,
    parameter int unsigned SEG_W        = 6,
    parameter int unsigned OPEN_W       = 7
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [SEG_W-1:0]           rd_idx,
    output logic [spba_pkg::CNT_W-1:0] rd_count,
    input  logic                       wr_en,
    input  logic [SEG_W-1:0]           wr_idx,
    input  logic [spba_pkg::CNT_W-1:0] wr_count,
    input  logic [OPEN_W-1:0]          opened,
    output logic                       free_found,
    output logic [SEG_W-1:0]           free_idx
);

    logic [spba_pkg::CNT_W-1:0] mem [MAX_SEGMENTS];
    logic [spba_pkg::CNT_W-1:0] rd_data_reg;
    logic                       rd_zero_reg;
    logic [MAX_SEGMENTS-1:0]    zero_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_count;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    // a set zero flag overrides the memory, so the memory needs no clearing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_reg    <= '1;
            rd_zero_reg <= 1'b1;
        end
        else
        begin
            if (wr_en)
            begin
                zero_reg[wr_idx] <= (wr_count == '0);
            end
            if (rd_en)
            begin
                rd_zero_reg <= zero_reg[rd_idx];
            end
        end
    end

    assign rd_count = rd_zero_reg ? '0 : rd_data_reg;

    // lowest opened segment with no live allocations
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_SEGMENTS - 1; i >= 0; i--)
        begin
            if (zero_reg[i] && (OPEN_W'(i) < opened))
            begin
                free_found = 1'b1;
                free_idx   = SEG_W'(i);
            end
        end
    end

endmodule

// ----- rtl/segment_pool_bump_allocator_core.sv -----
// top level of the segment pool bump allocator
//
//  channel | dir | handshake     | word
//  req     | in  | valid / ready | kind, alloc_size, free_address
//  rsp     | out | valid / ready | granted_address, status
//
// one item at a time; an allocate that fits the active segment, is too large or
// finds the pool exhausted ends in S_EVAL, one that moves to another segment in
// S_MOVE, a free in S_FEVAL after the address divide in S_FDIV and the count read.
// results wait in an output register; the next request is taken meanwhile.
// reset: segment 0 open at offset 4, all counts zero through the zero flags.
// a stalled output holds the item in progress at its last step.
module segment_pool_bump_allocator_core #(
    parameter int unsigned SEGMENT_BYTES = spba_pkg::SEGMENT_BYTES_DEF,
    parameter int unsigned MAX_SEGMENTS  = spba_pkg::MAX_SEGMENTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    spba_req_if.sink   req,
    spba_rsp_if.source rsp
);

    localparam int unsigned ADDR_W   = spba_pkg::ADDR_W;
    localparam int unsigned CNT_W    = spba_pkg::CNT_W;
    localparam int unsigned RND_W    = spba_pkg::RND_W;
    localparam int unsigned STATUS_W = spba_pkg::STATUS_W;
    localparam int unsigned SEG_W    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int unsigned OPEN_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int unsigned OFF_W    = $clog2(SEGMENT_BYTES + 1);
    localparam int unsigned SUM_W    = ((OFF_W > RND_W) ? OFF_W : RND_W) + 1;
    localparam int unsigned MB_W     = ADDR_W + OFF_W;

    // address / SEGMENT_BYTES as a multiply by a rounded-up reciprocal, exact below 2^19
    localparam int unsigned RECIP_SHIFT = 36;
    localparam int unsigned RECIP_W     = 31;
    localparam logic [63:0] RECIP =
        ((64'd1 << RECIP_SHIFT) + 64'(SEGMENT_BYTES) - 64'd1) / 64'(SEGMENT_BYTES);
    localparam int unsigned PROD_W = ADDR_W + RECIP_W;
    localparam int unsigned QUOT_W = PROD_W - RECIP_SHIFT;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_MOVE  = 3'd2;
    localparam logic [2:0] S_FDIV  = 3'd3;
    localparam logic [2:0] S_FEVAL = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [OPEN_W-1:0]   opened_reg, opened_next;
    logic [SEG_W-1:0]    active_reg, active_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [OFF_W-1:0]    bump_reg, bump_next;
    logic                out_valid_reg, out_valid_next;

    logic [RND_W-1:0]    rounded_reg, rounded_next;
    logic                too_large_reg, too_large_next;
    logic [PROD_W-1:0]   quot_prod_reg, quot_prod_next;
    logic                in_range_reg, in_range_next;
    logic [SEG_W-1:0]    fidx_reg, fidx_next;
    logic [SEG_W-1:0]    new_seg_reg, new_seg_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic                rd_en;
    logic [SEG_W-1:0]    rd_idx;
    logic [CNT_W-1:0]    rd_count;
    logic                wr_en;
    logic [SEG_W-1:0]    wr_idx;
    logic [CNT_W-1:0]    wr_count;
    logic                free_found;
    logic [SEG_W-1:0]    free_idx;

    logic                out_free;
    logic [RND_W-1:0]    rnd_sum;
    logic [RND_W-1:0]    rnd_in;
    logic [SUM_W-1:0]    bump_sum;
    logic [SUM_W-1:0]    move_sum;
    logic                fits;
    logic [MB_W-1:0]     move_base_full;
    logic [ADDR_W-1:0]   move_base;
    logic [QUOT_W-1:0]   quot;
    logic                quot_in_range;

    spba_count_store #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .SEG_W        (SEG_W),
        .OPEN_W       (OPEN_W)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (rd_en),
        .rd_idx     (rd_idx),
        .rd_count   (rd_count),
        .wr_en      (wr_en),
        .wr_idx     (wr_idx),
        .wr_count   (wr_count),
        .opened     (opened_reg),
        .free_found (free_found),
        .free_idx   (free_idx)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data.granted_address = out_addr_reg;
    assign rsp.data.status = out_status_reg;

    assign out_free = !out_valid_reg || rsp.ready;

    // round up to a multiple of 16
    assign rnd_sum = RND_W'(req.data.alloc_size) + RND_W'(spba_pkg::ROUND_ADD);
    assign rnd_in  = {rnd_sum[RND_W-1:4], 4'b0000};

    assign bump_sum = SUM_W'(bump_reg) + SUM_W'(rounded_reg);
    assign move_sum = SUM_W'(spba_pkg::RESERVED_BYTES) + SUM_W'(rounded_reg);
    assign fits     = (bump_sum <= SUM_W'(SEGMENT_BYTES)) && (rd_count != spba_pkg::COUNT_MAX);

    assign move_base_full = MB_W'(new_seg_reg) * MB_W'(SEGMENT_BYTES);
    assign move_base      = move_base_full[ADDR_W-1:0];

    assign quot          = quot_prod_reg[PROD_W-1:RECIP_SHIFT];
    assign quot_in_range = (quot < QUOT_W'(opened_reg));

    always_comb
    begin
        state_next      = state_reg;
        opened_next     = opened_reg;
        active_next     = active_reg;
        base_next       = base_reg;
        bump_next       = bump_reg;
        out_valid_next  = out_valid_reg;
        rounded_next    = rounded_reg;
        too_large_next  = too_large_reg;
        quot_prod_next  = quot_prod_reg;
        in_range_next   = in_range_reg;
        fidx_next       = fidx_reg;
        new_seg_next    = new_seg_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        rd_en           = 1'b0;
        rd_idx          = '0;
        wr_en           = 1'b0;
        wr_idx          = '0;
        wr_count        = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    rounded_next   = rnd_in;
                    too_large_next = (SUM_W'(rnd_in) + SUM_W'(spba_pkg::RESERVED_BYTES))
                                     > SUM_W'(SEGMENT_BYTES);
                    quot_prod_next = PROD_W'(req.data.free_address)
                                     * PROD_W'(RECIP[RECIP_W-1:0]);
                    if (req.data.kind == spba_pkg::KIND_FREE)
                    begin
                        state_next = S_FDIV;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_idx     = active_reg;
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL:
            begin
                if (out_free)
                begin
                    priority if (too_large_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_addr_next   = '0;
                        out_status_next = spba_pkg::ST_TOO_LARGE;
                        state_next      = S_IDLE;
                    end
                    else if (fits)
                    begin
                        wr_en           = 1'b1;
                        wr_idx          = active_reg;
                        wr_count        = rd_count + CNT_W'(1);
                        bump_next       = bump_sum[OFF_W-1:0];
                        out_valid_next  = 1'b1;
                        out_addr_next   = base_reg + ADDR_W'(bump_reg);
                        out_status_next = spba_pkg::ST_OK;
                        state_next      = S_IDLE;
                    end
                    else if (free_found)
                    begin
                        new_seg_next = free_idx;
                        state_next   = S_MOVE;
                    end
                    else if (opened_reg < OPEN_W'(MAX_SEGMENTS))
                    begin
                        new_seg_next = opened_reg[SEG_W-1:0];
                        opened_next  = opened_reg + OPEN_W'(1);
                        state_next   = S_MOVE;
                    end
                    else
                    begin
                        out_valid_next  = 1'b1;
                        out_addr_next   = '0;
                        out_status_next = spba_pkg::ST_EXHAUSTED;
                        state_next      = S_IDLE;
                    end
                end
            end
            S_MOVE:
            begin
                // target segment has no live allocations: its count becomes one
                if (out_free)
                begin
                    wr_en           = 1'b1;
                    wr_idx          = new_seg_reg;
                    wr_count        = CNT_W'(1);
                    active_next     = new_seg_reg;
                    base_next       = move_base;
                    bump_next       = move_sum[OFF_W-1:0];
                    out_valid_next  = 1'b1;
                    out_addr_next   = move_base + ADDR_W'(spba_pkg::RESERVED_BYTES);
                    out_status_next = spba_pkg::ST_OK;
                    state_next      = S_IDLE;
                end
            end
            S_FDIV:
            begin
                rd_en         = quot_in_range;
                rd_idx        = quot_in_range ? quot[SEG_W-1:0] : '0;
                in_range_next = quot_in_range;
                fidx_next     = quot[SEG_W-1:0];
                state_next    = S_FEVAL;
            end
            S_FEVAL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = '0;
                    if (!in_range_reg || (rd_count == '0))
                    begin
                        out_status_next = spba_pkg::ST_BAD_FREE;
                    end
                    else
                    begin
                        wr_en           = 1'b1;
                        wr_idx          = fidx_reg;
                        wr_count        = rd_count - CNT_W'(1);
                        out_status_next = spba_pkg::ST_OK;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            opened_reg    <= OPEN_W'(1);
            active_reg    <= '0;
            base_reg      <= '0;
            bump_reg      <= OFF_W'(spba_pkg::RESERVED_BYTES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            opened_reg    <= opened_next;
            active_reg    <= active_next;
            base_reg      <= base_next;
            bump_reg      <= bump_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rounded_reg    <= rounded_next;
        too_large_reg  <= too_large_next;
        quot_prod_reg  <= quot_prod_next;
        in_range_reg   <= in_range_next;
        fidx_reg       <= fidx_next;
        new_seg_reg    <= new_seg_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

`ifndef SYNTH
    a_bump_in_segment: assert property (@(posedge clk) disable iff (!rst_n)
        SUM_W'(bump_reg) <= SUM_W'(SEGMENT_BYTES))
        else $error("bump offset beyond segment end");

    a_opened_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (opened_reg != '0) && (opened_reg <= OPEN_W'(MAX_SEGMENTS)))
        else $error("opened segment count out of bounds");

    a_active_opened: assert property (@(posedge clk) disable iff (!rst_n)
        OPEN_W'(active_reg) < opened_reg)
        else $error("active segment not opened");

    a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("count memory read and write in the same cycle");

    a_refused_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != spba_pkg::ST_OK) |-> (out_addr_reg == '0))
        else $error("refused item carries an address");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// self-checking testbench of the segment pool bump allocator core
module tb_top;

    localparam int unsigned SEG_BYTES = spba_pkg::SEGMENT_BYTES_DEF;
    localparam int unsigned POOL_SEGS = spba_pkg::MAX_SEGMENTS_DEF;
    localparam int unsigned KIND_W    = spba_pkg::KIND_W;
    localparam int unsigned SIZE_W    = spba_pkg::SIZE_W;
    localparam int unsigned ADDR_W    = spba_pkg::ADDR_W;
    localparam int unsigned STATUS_W  = spba_pkg::STATUS_W;
    localparam int unsigned CNT_W     = spba_pkg::CNT_W;
    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_CYCLES = 60;
    localparam int RANDOM_WORDS = 118;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [SIZE_W-1:0]   size;
        logic [ADDR_W-1:0]   addr;
        int                  reps;
        bit                  typed;
        logic [ADDR_W-1:0]   want_addr;
        logic [STATUS_W-1:0] want_st;
    } step_t;

    localparam step_t PLAN [18] = '{
        '{spba_pkg::KIND_FREE,  0,     0,      1,  1, 0,     spba_pkg::ST_BAD_FREE},
        '{spba_pkg::KIND_FREE,  0,     524287, 1,  1, 0,     spba_pkg::ST_BAD_FREE},
        '{spba_pkg::KIND_ALLOC, 0,     0,      1,  1, 4,     spba_pkg::ST_OK},
        '{spba_pkg::KIND_ALLOC, 1,     0,      1,  1, 4,     spba_pkg::ST_OK},
        '{spba_pkg::KIND_ALLOC, 8177,  0,      1,  1, 0,     spba_pkg::ST_TOO_LARGE},
        '{spba_pkg::KIND_ALLOC, 16383, 0,      1,  1, 0,     spba_pkg::ST_TOO_LARGE},
        // largest size that fits, has to open segment 1
        '{spba_pkg::KIND_ALLOC, 8176,  0,      1,  0, 0,     spba_pkg::ST_OK},
        '{spba_pkg::KIND_FREE,  0,     4,      1,  0, 0,     spba_pkg::ST_OK},
        // reserved bytes belong to segment 0
        '{spba_pkg::KIND_FREE,  0,     3,      1,  0, 0,     spba_pkg::ST_OK},
        '{spba_pkg::KIND_FREE,  0,     4,      1,  1, 0,     spba_pkg::ST_BAD_FREE},
        // segment 1 is full, empty segment 0 gets reused
        '{spba_pkg::KIND_ALLOC, 16,    0,      1,  0, 0,     spba_pkg::ST_OK},
        // nothing empty, segment 2 gets opened
        '{spba_pkg::KIND_ALLOC, 8176,  0,      1,  1, 16388, spba_pkg::ST_OK},
        // open every remaining segment
        '{spba_pkg::KIND_ALLOC, 8176,  0,      61, 0, 0,     spba_pkg::ST_OK},
        '{spba_pkg::KIND_ALLOC, 8176,  0,      1,  1, 0,     spba_pkg::ST_EXHAUSTED},
        '{spba_pkg::KIND_FREE,  0,     8196,   1,  0, 0,     spba_pkg::ST_OK},
        '{spba_pkg::KIND_ALLOC, 8176,  0,      1,  1, 8196,  spba_pkg::ST_OK},
        '{spba_pkg::KIND_FREE,  0,     524287, 1,  0, 0,     spba_pkg::ST_OK},
        '{spba_pkg::KIND_FREE,  0,     524287, 1,  1, 0,     spba_pkg::ST_BAD_FREE}
    };

    logic clk;
    logic rst_n;

    spba_req_if req_ch ();
    spba_rsp_if rsp_ch ();

    segment_pool_bump_allocator_core #(
        .SEGMENT_BYTES(SEG_BYTES),
        .MAX_SEGMENTS (POOL_SEGS)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch.sink),
        .rsp  (rsp_ch.source)
    );

    // predicted allocator state
    logic [CNT_W-1:0] seg_live [POOL_SEGS];
    int unsigned      segs_opened;
    int unsigned      cur_seg;
    int unsigned      cur_pos;

    spba_pkg::rsp_t    pending_replies [$];
    logic [ADDR_W-1:0] live_grants [$];

    int src_idle_pct;
    int sink_idle_pct;
    int hold_left;
    int quiet_cycles;
    int errors;
    int n_sent;
    int n_checked;
    int n_granted;
    int n_exhausted;
    int n_too_large;
    int n_bad_free;

    function automatic spba_pkg::rsp_t predict_reply(spba_pkg::req_t w);
        int unsigned rnd;
        int unsigned seg;
        bit hit;
        spba_pkg::rsp_t r;
        r = '0;
        r.status = spba_pkg::ST_OK;
        if (w.kind == spba_pkg::KIND_ALLOC)
        begin
            rnd = w.alloc_size;
            rnd = (rnd + spba_pkg::ROUND_ADD) & ~spba_pkg::ROUND_ADD;
            if (rnd + spba_pkg::RESERVED_BYTES > SEG_BYTES)
            begin
                r.status = spba_pkg::ST_TOO_LARGE;
            end
            else
            begin
                if (cur_pos + rnd > SEG_BYTES || seg_live[cur_seg] == spba_pkg::COUNT_MAX)
                begin
                    hit = 1'b0;
                    // lowest opened segment with nothing live
                    for (seg = 0; seg < segs_opened; seg++)
                    begin
                        if (seg_live[seg] == '0)
                        begin
                            hit = 1'b1;
                            break;
                        end
                    end
                    if (!hit && segs_opened >= POOL_SEGS)
                    begin
                        r.status = spba_pkg::ST_EXHAUSTED;
                    end
                    else
                    begin
                        if (!hit)
                        begin
                            seg = segs_opened;
                            segs_opened++;
                            seg_live[seg] = '0;
                        end
                        cur_seg = seg;
                        cur_pos = spba_pkg::RESERVED_BYTES;
                    end
                end
                if (r.status == spba_pkg::ST_OK)
                begin
                    r.granted_address = ADDR_W'(cur_seg * SEG_BYTES + cur_pos);
                    cur_pos += rnd;
                    seg_live[cur_seg]++;
                end
            end
        end
        else
        begin
            seg = w.free_address / SEG_BYTES;
            if (seg >= segs_opened || seg >= POOL_SEGS || seg_live[seg] == '0)
                r.status = spba_pkg::ST_BAD_FREE;
            else
                seg_live[seg]--;
        end
        return r;
    endfunction

    // mostly allocations and frees of live grants, some junk frees and oversize requests
    function automatic spba_pkg::req_t random_word();
        spba_pkg::req_t w;
        int pick;
        int idx;
        int szc;
        w.kind = spba_pkg::KIND_ALLOC;
        w.alloc_size = SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1));
        w.free_address = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            szc = $urandom_range(0, 9);
            if (szc < 7)
                w.alloc_size = SIZE_W'($urandom_range(0, 480));
            else if (szc < 9)
                w.alloc_size = SIZE_W'($urandom_range(0, 8176));
        end
        else if (pick < 88 && live_grants.size() > 0)
        begin
            idx = $urandom_range(0, live_grants.size() - 1);
            w.kind = spba_pkg::KIND_FREE;
            w.free_address = live_grants[idx];
            live_grants.delete(idx);
        end
        else
        begin
            w.kind = spba_pkg::KIND_FREE;
        end
        return w;
    endfunction

    // entered and left at a falling edge
    task automatic send_word(input spba_pkg::req_t w, input bit typed,
                             input spba_pkg::rsp_t want);
        spba_pkg::rsp_t got;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= w;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        got = predict_reply(w);
        pending_replies = {pending_replies, (typed ? want : got)};
        if (w.kind == spba_pkg::KIND_ALLOC && got.status == spba_pkg::ST_OK
            && w.alloc_size != 0)
            live_grants = {live_grants, got.granted_address};
        n_sent++;
    endtask

    task automatic drain_replies();
        req_ch.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        spba_pkg::rsp_t exp_r;
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            n_checked++;
            case (rsp_ch.data.status)
                spba_pkg::ST_OK:
                    if (rsp_ch.data.granted_address != 0) n_granted++;
                spba_pkg::ST_EXHAUSTED: n_exhausted++;
                spba_pkg::ST_TOO_LARGE: n_too_large++;
                default:                n_bad_free++;
            endcase
            if (pending_replies.size() == 0)
            begin
                errors++;
                $display("%0t: reply with nothing pending, expected none,",
                         $time, " got addr %0d status %0d",
                         rsp_ch.data.granted_address, rsp_ch.data.status);
            end
            else
            begin
                exp_r = pending_replies.pop_front();
                if (rsp_ch.data.granted_address !== exp_r.granted_address ||
                    rsp_ch.data.status !== exp_r.status)
                begin
                    errors++;
                    $display("%0t: reply mismatch, expected addr %0d status %0d,",
                             $time, exp_r.granted_address, exp_r.status,
                             " got addr %0d status %0d",
                             rsp_ch.data.granted_address, rsp_ch.data.status);
                end
            end
        end
    end

    initial
    begin
        spba_pkg::req_t word;
        spba_pkg::rsp_t want;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        hold_left = 0;
        quiet_cycles = 0;
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_granted = 0;
        n_exhausted = 0;
        n_too_large = 0;
        n_bad_free = 0;
        foreach (seg_live[i])
            seg_live[i] = '0;
        segs_opened = 1;
        cur_seg = 0;
        cur_pos = spba_pkg::RESERVED_BYTES;
        src_idle_pct = 7;
        sink_idle_pct = 70;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (PLAN[i])
        begin
            word.kind = PLAN[i].kind;
            word.alloc_size = PLAN[i].size;
            word.free_address = PLAN[i].addr;
            want.granted_address = PLAN[i].want_addr;
            want.status = PLAN[i].want_st;
            repeat (PLAN[i].reps) send_word(word, PLAN[i].typed, want);
        end
        repeat (RANDOM_WORDS) send_word(random_word(), 1'b0, '0);

        // output held off while the sender keeps pushing
        req_ch.valid <= 1'b0;
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        @(negedge clk);
        src_idle_pct = 0;
        repeat (16) send_word(random_word(), 1'b0, '0);
        drain_replies();

        src_idle_pct = 70;
        sink_idle_pct = 7;
        repeat (RANDOM_WORDS) send_word(random_word(), 1'b0, '0);
        drain_replies();

        src_idle_pct = 0;
        sink_idle_pct = 0;
        repeat (RANDOM_WORDS) send_word(random_word(), 1'b0, '0);
        drain_replies();
        repeat (10) @(posedge clk);

        $display("%0d words sent, %0d replies checked", n_sent, n_checked);
        $display("grants %0d, pool exhausted %0d, too large %0d, bad frees %0d",
                 n_granted, n_exhausted, n_too_large, n_bad_free);
        if (errors == 0 && pending_replies.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/spba_pkg.sv
rtl/spba_req_if.sv
rtl/spba_rsp_if.sv
rtl/spba_count_store.sv
rtl/segment_pool_bump_allocator_core.sv
verif/tb_top.sv
